// ===== rtl/bvta_pkg.sv =====
// Shared types, constants and the decay table for the ball tensor vote accumulator.
// Used by every module in rtl/; depends on nothing.
package bvta_pkg;

  localparam int ACC_WIDTH       = 48;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int IDX_W           = $clog2(EXP_TABLE_DEPTH);
  localparam int FIFO_DEPTH      = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int NUM_ELEM        = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_X     = 3'd0,
    CFG_SOURCE_Y     = 3'd1,
    CFG_SOURCE_Z     = 3'd2,
    CFG_INV_SIGMA_SQ = 3'd3,
    CFG_LAMBDA_SCALE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               last_point;
  } in_t;

  typedef struct packed {
    logic signed [47:0] tensor_xx;
    logic signed [47:0] tensor_xy;
    logic signed [47:0] tensor_xz;
    logic signed [47:0] tensor_yy;
    logic signed [47:0] tensor_yz;
    logic signed [47:0] tensor_zz;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic signed [31:0] source_x;
    logic signed [31:0] source_y;
    logic signed [31:0] source_z;
    logic        [31:0] inv_sigma_sq;
    logic        [31:0] lambda_scale;
  } cfg_t;

  // One classified point: offset magnitudes and signs per axis.
  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic             skip;
    logic             last;
  } entry_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_SQZ, ST_S2Z, ST_TLO, ST_THI, ST_TCHK,
    ST_NORM, ST_PROD, ST_NSUM, ST_DIV0, ST_DIVS, ST_VOTE1, ST_VOTE2,
    ST_VOTE3, ST_EMIT
  } back_state_e;

  // Row and column of each unique tensor element: xx xy xz yy yz zz.
  localparam logic [1:0] ELEM_ROW [NUM_ELEM] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] ELEM_COL [NUM_ELEM] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

  typedef logic [31:0] decay_tab_t [EXP_TABLE_DEPTH];

  // exp(-16*i/DEPTH) in Q16.16, stepped in Q2.30.
  function automatic decay_tab_t build_decay_table();
    logic [63:0] h;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] step;
    logic [63:0] cur;
    decay_tab_t  tab;
    h    = (64'd16 << 30) / EXP_TABLE_DEPTH;
    term = 64'd1 << 30;
    sum  = 64'd1 << 30;
    for (int n = 1; n <= 14; n++) begin
      term = ((term * h) >> 30) / 64'(n);
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    step = sum;
    cur  = 64'd1 << 30;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      tab[i] = 32'((cur + 64'h2000) >> 14);
      cur    = (cur * step + (64'd1 << 29)) >> 30;
    end
    return tab;
  endfunction

  localparam decay_tab_t DECAY_TABLE = build_decay_table();

endpackage

// ===== rtl/ball_tensor_vote_accumulator.sv =====
// Top level of the ball tensor vote accumulator: configuration registers,
// result register and the front end / queue / vote engine. Depends on bvta_pkg.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   in_data_i  (bvta_pkg::in_t)
//   out      output     out_valid_o / out_stall_i out_data_o (bvta_pkg::out_t)
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A point at zero offset goes straight from idle to emit in the vote engine. For a
// voting point the bit-serial divider works through each of the six projections,
// after the shift that narrows the offset until the largest axis fits in 20 bits.
// The two-entry queue takes points while the engine is busy.
// Reset clears the accumulators, the clip flag, the queue and the result valid flag.
// A stalled result holds in its register; the engine waits on the next emit only.
module ball_tensor_vote_accumulator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  bvta_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output bvta_pkg::out_t                     out_data_o,
  input  logic                               cfg_we_i,
  input  logic [bvta_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [31:0]                        cfg_data_i
);
  import bvta_pkg::*;

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  cfg_t             cfg_q;
  entry_t           entry_w, head_w;
  logic             full_w, empty_w, push_w, pop_w;
  logic [CNT_W-1:0] fifo_cnt_w;
  logic             emit_w;
  out_t             result_w;
  logic             out_valid_q;
  out_t             out_q;
  logic             out_free_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_x     <= '0;
      cfg_q.source_y     <= '0;
      cfg_q.source_z     <= '0;
      cfg_q.inv_sigma_sq <= 32'd65536;
      cfg_q.lambda_scale <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SOURCE_X:     cfg_q.source_x     <= cfg_data_i;
        CFG_SOURCE_Y:     cfg_q.source_y     <= cfg_data_i;
        CFG_SOURCE_Z:     cfg_q.source_z     <= cfg_data_i;
        CFG_INV_SIGMA_SQ: cfg_q.inv_sigma_sq <= cfg_data_i;
        CFG_LAMBDA_SCALE: cfg_q.lambda_scale <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = full_w;
  assign push_w     = in_valid_i && !full_w;

  bvta_front u_front (
    .in_data_i (in_data_i),
    .cfg_i     (cfg_q),
    .entry_o   (entry_w)
  );

  bvta_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_w),
    .wdata_i (entry_w),
    .pop_i   (pop_w),
    .rdata_o (head_w),
    .full_o  (full_w),
    .empty_o (empty_w),
    .count_o (fifo_cnt_w)
  );

  assign out_free_w = !out_valid_q || !out_stall_i;

  bvta_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .entry_i    (head_w),
    .empty_i    (empty_w),
    .pop_o      (pop_w),
    .out_free_i (out_free_w),
    .emit_o     (emit_w),
    .result_o   (result_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_w) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_w) out_q <= result_w;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_w |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while held");

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_w <= CNT_W'(FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_w |=> (fifo_cnt_w != '0))
    else $error("transfer into queue lost");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_w |-> !empty_w)
    else $error("pop from empty queue");

endmodule

// ===== rtl/bvta_front.sv =====
// Front end: forms the offset from the source point and classifies each point.
// Depends on bvta_pkg.
module bvta_front (
  input  bvta_pkg::in_t    in_data_i,
  input  bvta_pkg::cfg_t   cfg_i,
  output bvta_pkg::entry_t entry_o
);
  import bvta_pkg::*;

  logic signed [32:0] d [3];
  logic signed [32:0] nd [3];

  always_comb begin
    d[0] = {in_data_i.point_x[31], in_data_i.point_x} - {cfg_i.source_x[31], cfg_i.source_x};
    d[1] = {in_data_i.point_y[31], in_data_i.point_y} - {cfg_i.source_y[31], cfg_i.source_y};
    d[2] = {in_data_i.point_z[31], in_data_i.point_z} - {cfg_i.source_z[31], cfg_i.source_z};
    for (int i = 0; i < 3; i++) begin
      nd[i]          = -d[i];
      entry_o.neg[i] = d[i][32];
      entry_o.mag[i] = d[i][32] ? nd[i][31:0] : d[i][31:0];
    end
    entry_o.skip = (d[0] == 33'sd0) && (d[1] == 33'sd0) && (d[2] == 33'sd0);
    entry_o.last = in_data_i.last_point;
  end

endmodule

// ===== rtl/bvta_fifo.sv =====
// Short queue of classified points between the front end and the vote engine.
// Depends on bvta_pkg.
module bvta_fifo (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  input  bvta_pkg::entry_t                     wdata_i,
  input  logic                                 pop_i,
  output bvta_pkg::entry_t                     rdata_o,
  output logic                                 full_o,
  output logic                                 empty_o,
  output logic [$clog2(bvta_pkg::FIFO_DEPTH+1)-1:0] count_o
);
  import bvta_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  entry_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/bvta_back.sv =====
// Vote engine: decay lookup, projection by a bit-serial divider and saturating
// accumulation on one shared multiplier. Depends on bvta_pkg.
module bvta_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bvta_pkg::cfg_t   cfg_i,
  input  bvta_pkg::entry_t entry_i,
  input  logic             empty_i,
  output logic             pop_o,
  input  logic             out_free_i,
  output logic             emit_o,
  output bvta_pkg::out_t   result_o
);
  import bvta_pkg::*;

  localparam int W_W   = 35;
  localparam int SUM_W = ((ACC_WIDTH > W_W) ? ACC_WIDTH : W_W) + 1;
  localparam int TM_W  = 36 + IDX_W + 1;
  localparam logic signed [SUM_W-1:0] ACC_MAX =
    $signed((SUM_W'(1) << (ACC_WIDTH - 1)) - SUM_W'(1));
  localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);

  back_state_e state_q, state_d;

  logic [31:0]  mag_q [3];
  logic [2:0]   neg_q;
  logic         last_q;
  logic [31:0]  m_q;
  logic [49:0]  s2_q;
  logic [63:0]  tlo_q;
  logic [16:0]  c_q;
  logic [63:0]  p_q;
  logic [39:0]  ee_q [NUM_ELEM];
  logic [41:0]  n_q;
  logic [42:0]  r_q;
  logic [16:0]  quo_q;
  logic [3:0]   cnt_q;
  logic [2:0]   elem_q;
  logic [2:0]   j_q;
  logic         xneg_q;
  logic signed [ACC_WIDTH-1:0] acc_q [NUM_ELEM];
  logic         clip_q;

  logic [31:0]  mul_a, mul_b;
  logic [31:0]  ent_max;
  logic [81:0]  t_full;
  logic [TM_W-1:0] t_mul;
  logic [41:0]  n_sum;
  logic [42:0]  r_dbl;
  logic         pneg;
  logic signed [18:0] x_val;
  logic signed [18:0] x_abs;
  logic [32:0]  w_mag;
  logic signed [W_W-1:0] w_val;
  logic signed [SUM_W-1:0] acc_sum;
  logic         load_start;

  always_comb begin
    ent_max = entry_i.mag[0];
    if (entry_i.mag[1] > ent_max) ent_max = entry_i.mag[1];
    if (entry_i.mag[2] > ent_max) ent_max = entry_i.mag[2];
    t_full  = {p_q[49:0], 32'd0} + {18'd0, tlo_q};
    t_mul   = TM_W'(t_full[35:0]) * TM_W'(EXP_TABLE_DEPTH);
    n_sum   = 42'(ee_q[0]) + 42'(ee_q[3]) + 42'(ee_q[5]);
    r_dbl   = {r_q[41:0], 1'b0};
    pneg    = neg_q[ELEM_ROW[elem_q]] ^ neg_q[ELEM_COL[elem_q]];
    x_val   = ((ELEM_ROW[elem_q] == ELEM_COL[elem_q]) ? 19'sd65536 : 19'sd0)
              - (pneg ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q}));
    x_abs   = x_val[18] ? -x_val : x_val;
    w_mag   = p_q[48:16];
    w_val   = xneg_q ? -$signed({2'b00, w_mag}) : $signed({2'b00, w_mag});
    acc_sum = SUM_W'(acc_q[elem_q]) + SUM_W'(w_val);
  end

  // Shared multiplier operand select.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQX:   begin mul_a = mag_q[0]; mul_b = mag_q[0]; end
      ST_SQY:   begin mul_a = mag_q[1]; mul_b = mag_q[1]; end
      ST_SQZ:   begin mul_a = mag_q[2]; mul_b = mag_q[2]; end
      ST_TLO:   begin mul_a = s2_q[31:0]; mul_b = cfg_i.inv_sigma_sq; end
      ST_THI:   begin mul_a = {14'd0, s2_q[49:32]}; mul_b = cfg_i.inv_sigma_sq; end
      ST_PROD: begin
        if (j_q < 3'(NUM_ELEM)) begin
          mul_a = mag_q[ELEM_ROW[j_q]];
          mul_b = mag_q[ELEM_COL[j_q]];
        end
      end
      ST_VOTE1: begin mul_a = {15'd0, x_abs[16:0]}; mul_b = {15'd0, c_q}; end
      ST_VOTE2: begin mul_a = {15'd0, p_q[32:16]}; mul_b = cfg_i.lambda_scale; end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    pop_o      = 1'b0;
    emit_o     = 1'b0;
    load_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o      = 1'b1;
          load_start = 1'b1;
          state_d    = entry_i.skip ? ST_EMIT : ST_SQX;
        end
      end
      ST_SQX:  state_d = ST_SQY;
      ST_SQY:  state_d = ST_SQZ;
      ST_SQZ:  state_d = ST_S2Z;
      ST_S2Z:  state_d = ST_TLO;
      ST_TLO:  state_d = ST_THI;
      ST_THI:  state_d = ST_TCHK;
      ST_TCHK: state_d = ST_NORM;
      ST_NORM: begin
        if (m_q[31:20] == '0) state_d = ST_PROD;
      end
      ST_PROD: begin
        if (j_q == 3'(NUM_ELEM)) state_d = ST_NSUM;
      end
      ST_NSUM: state_d = (n_sum == '0) ? ST_EMIT : ST_DIV0;
      ST_DIV0: state_d = ST_DIVS;
      ST_DIVS: begin
        if (cnt_q == 4'd15) state_d = ST_VOTE1;
      end
      ST_VOTE1: state_d = ST_VOTE2;
      ST_VOTE2: state_d = ST_VOTE3;
      ST_VOTE3: state_d = (elem_q == 3'(NUM_ELEM - 1)) ? ST_EMIT : ST_DIV0;
      ST_EMIT: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (out_free_i) begin
          emit_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Accumulators and clip flag: cleared at reset and on every emit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ELEM; i++) acc_q[i] <= '0;
      clip_q <= 1'b0;
    end else if (emit_o) begin
      for (int i = 0; i < NUM_ELEM; i++) acc_q[i] <= '0;
      clip_q <= 1'b0;
    end else if (state_q == ST_VOTE3) begin
      if (acc_sum > ACC_MAX) begin
        acc_q[elem_q] <= ACC_MAX[ACC_WIDTH-1:0];
        clip_q        <= 1'b1;
      end else if (acc_sum < ACC_MIN) begin
        acc_q[elem_q] <= ACC_MIN[ACC_WIDTH-1:0];
        clip_q        <= 1'b1;
      end else begin
        acc_q[elem_q] <= acc_sum[ACC_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    if (load_start) begin
      for (int i = 0; i < 3; i++) mag_q[i] <= entry_i.mag[i];
      neg_q  <= entry_i.neg;
      last_q <= entry_i.last;
      m_q    <= ent_max;
    end
    unique case (state_q)
      ST_SQY: s2_q <= 50'(p_q[63:16]);
      ST_SQZ: s2_q <= s2_q + 50'(p_q[63:16]);
      ST_S2Z: s2_q <= s2_q + 50'(p_q[63:16]);
      ST_THI: tlo_q <= p_q;
      ST_TCHK: begin
        c_q <= (t_full[81:36] != '0) ? 17'd0 : DECAY_TABLE[t_mul[36 +: IDX_W]][16:0];
        j_q <= '0;
      end
      ST_NORM: begin
        // Drop one bit of every axis until the largest fits in 20 bits.
        if (m_q[31:20] != '0) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
          m_q <= m_q >> 1;
        end
      end
      ST_PROD: begin
        if (j_q != '0) ee_q[j_q - 3'd1] <= p_q[39:0];
        j_q <= j_q + 3'd1;
      end
      ST_NSUM: begin
        n_q    <= n_sum;
        elem_q <= '0;
      end
      ST_DIV0: begin
        if ({3'd0, ee_q[elem_q]} >= n_q) begin
          r_q   <= 43'(ee_q[elem_q]) - 43'(n_q);
          quo_q <= 17'd1;
        end else begin
          r_q   <= 43'(ee_q[elem_q]);
          quo_q <= 17'd0;
        end
        cnt_q <= '0;
      end
      ST_DIVS: begin
        if (r_dbl >= 43'(n_q)) begin
          r_q   <= r_dbl - 43'(n_q);
          quo_q <= {quo_q[15:0], 1'b1};
        end else begin
          r_q   <= r_dbl;
          quo_q <= {quo_q[15:0], 1'b0};
        end
        cnt_q <= cnt_q + 4'd1;
      end
      ST_VOTE1: xneg_q <= x_val[18];
      ST_VOTE3: elem_q <= elem_q + 3'd1;
      default: begin
      end
    endcase
  end

  always_comb begin
    logic signed [63:0] ext [NUM_ELEM];
    for (int i = 0; i < NUM_ELEM; i++) ext[i] = 64'(acc_q[i]);
    result_o.tensor_xx = ext[0][47:0];
    result_o.tensor_xy = ext[1][47:0];
    result_o.tensor_xz = ext[2][47:0];
    result_o.tensor_yy = ext[3][47:0];
    result_o.tensor_yz = ext[4][47:0];
    result_o.tensor_zz = ext[5][47:0];
    result_o.saturated = clip_q;
  end

endmodule

// ===== tb/ball_tensor_vote_accumulator_checker.sv =====
// Checker for the ball tensor vote accumulator: watches the cfg, in and out ports,
// predicts each emitted tensor and compares it field by field. Depends on bvta_pkg.
`timescale 1ns / 1ps

module ball_tensor_vote_accumulator_checker
  import bvta_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  in_t                  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  out_t                 out_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  logic [31:0] decay_lut [EXP_TABLE_DEPTH];
  cfg_t        cfg_shadow;
  longint      tensor_sum [NUM_ELEM];
  logic        clip_seen;
  out_t        tensor_expect_q [$];

  initial begin
    logic [63:0] h;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] cur;
    h    = (64'd16 << 30) / EXP_TABLE_DEPTH;
    term = 64'd1 << 30;
    acc  = 64'd1 << 30;
    for (int n = 1; n <= 14; n++) begin
      term = ((term * h) >> 30) / 64'(n);
      if (n & 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    cur = 64'd1 << 30;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      decay_lut[i] = 32'((cur + 64'h2000) >> 14);
      cur = (cur * acc + (64'd1 << 29)) >> 30;
    end
    fail_count_o = 0;
  end

  assign pending_o = tensor_expect_q.size();

  task automatic report(string what, longint got, longint want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // Signed Q16.16 times unsigned, truncated toward zero.
  function automatic longint scale_q16(longint a, logic [63:0] b);
    logic [63:0] mg;
    logic [63:0] p;
    mg = (a < 0) ? 64'(-a) : 64'(a);
    p  = (mg * b) >> 16;
    return (a < 0) ? -longint'(p) : longint'(p);
  endfunction

  task automatic add_clipped(int idx, longint w);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (ACC_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (w > 0 && tensor_sum[idx] > hi - w) begin
      tensor_sum[idx] = hi;
      clip_seen = 1'b1;
    end else if (w < 0 && tensor_sum[idx] < lo - w) begin
      tensor_sum[idx] = lo;
      clip_seen = 1'b1;
    end else begin
      tensor_sum[idx] = tensor_sum[idx] + w;
    end
  endtask

  task automatic fold_vote(in_t pt);
    longint      d [3];
    logic [63:0] mag [3];
    logic [63:0] em [3];
    logic        neg [3];
    logic [63:0] s2;
    logic [63:0] m;
    logic [63:0] n;
    logic [63:0] c;
    logic [63:0] inv;
    logic [63:0] pm;
    int          k;
    int          r;
    int          q;
    longint      pv;
    longint      v;
    d[0] = longint'(pt.point_x) - longint'(cfg_shadow.source_x);
    d[1] = longint'(pt.point_y) - longint'(cfg_shadow.source_y);
    d[2] = longint'(pt.point_z) - longint'(cfg_shadow.source_z);
    if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
      return;
    end
    s2 = '0;
    m  = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = d[i] < 0;
      mag[i] = neg[i] ? 64'(-d[i]) : 64'(d[i]);
      s2 += (mag[i] * mag[i]) >> 16;
      if (mag[i] > m) begin
        m = mag[i];
      end
    end
    inv = 64'(cfg_shadow.inv_sigma_sq);
    // Exponent at or past 16.0 decays to zero.
    if (inv != 0 && s2 > ((64'd1 << 36) - 1) / inv) begin
      c = '0;
    end else begin
      c = 64'(decay_lut[((s2 * inv) * EXP_TABLE_DEPTH) >> 36]);
    end
    k = 0;
    while ((m >> k) >= (64'd1 << 20)) begin
      k++;
    end
    n = '0;
    for (int i = 0; i < 3; i++) begin
      em[i] = mag[i] >> k;
      n += em[i] * em[i];
    end
    if (n == 0) begin
      return;
    end
    for (int i = 0; i < NUM_ELEM; i++) begin
      r  = int'(ELEM_ROW[i]);
      q  = int'(ELEM_COL[i]);
      pm = ((em[r] * em[q]) << 16) / n;
      pv = (neg[r] != neg[q]) ? -longint'(pm) : longint'(pm);
      v  = scale_q16(((r == q) ? 65536 : 0) - pv, c);
      add_clipped(i, scale_q16(v, 64'(cfg_shadow.lambda_scale)));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t got;
    out_t want;
    if (!rst_ni) begin
      cfg_shadow <= '{source_x: '0, source_y: '0, source_z: '0,
                      inv_sigma_sq: 32'd65536, lambda_scale: 32'd65536};
      for (int i = 0; i < NUM_ELEM; i++) begin
        tensor_sum[i] = 0;
      end
      clip_seen = 1'b0;
      tensor_expect_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (tensor_expect_q.size() == 0) begin
          report("unexpected tensor", longint'(got.tensor_xx), 0);
        end else begin
          want = tensor_expect_q.pop_front();
          if (got.tensor_xx !== want.tensor_xx) report("tensor_xx", got.tensor_xx, want.tensor_xx);
          if (got.tensor_xy !== want.tensor_xy) report("tensor_xy", got.tensor_xy, want.tensor_xy);
          if (got.tensor_xz !== want.tensor_xz) report("tensor_xz", got.tensor_xz, want.tensor_xz);
          if (got.tensor_yy !== want.tensor_yy) report("tensor_yy", got.tensor_yy, want.tensor_yy);
          if (got.tensor_yz !== want.tensor_yz) report("tensor_yz", got.tensor_yz, want.tensor_yz);
          if (got.tensor_zz !== want.tensor_zz) report("tensor_zz", got.tensor_zz, want.tensor_zz);
          if (got.saturated !== want.saturated) report("saturated", got.saturated, want.saturated);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        fold_vote(in_data_i);
        if (in_data_i.last_point) begin
          want.tensor_xx = tensor_sum[0][47:0];
          want.tensor_xy = tensor_sum[1][47:0];
          want.tensor_xz = tensor_sum[2][47:0];
          want.tensor_yy = tensor_sum[3][47:0];
          want.tensor_yz = tensor_sum[4][47:0];
          want.tensor_zz = tensor_sum[5][47:0];
          want.saturated = clip_seen;
          tensor_expect_q.push_back(want);
          for (int i = 0; i < NUM_ELEM; i++) begin
            tensor_sum[i] = 0;
          end
          clip_seen = 1'b0;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SOURCE_X:     cfg_shadow.source_x <= cfg_data_i;
          CFG_SOURCE_Y:     cfg_shadow.source_y <= cfg_data_i;
          CFG_SOURCE_Z:     cfg_shadow.source_z <= cfg_data_i;
          CFG_INV_SIGMA_SQ: cfg_shadow.inv_sigma_sq <= cfg_data_i;
          CFG_LAMBDA_SCALE: cfg_shadow.lambda_scale <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/ball_tensor_vote_accumulator_test.sv =====
// Testbench top for the ball tensor vote accumulator: clock, reset, stimulus and
// verdict. Depends on bvta_pkg, the block and ball_tensor_vote_accumulator_checker.
`timescale 1ns / 1ps

module ball_tensor_vote_accumulator_test;
  import bvta_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam int DRAIN_CYCLES = 600;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_t                  in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_t                 out_data_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0]          cfg_data_i;
  int                   fail_count;
  int                   pending;
  logic                 idle_on;
  cfg_t                 cur_cfg;

  ball_tensor_vote_accumulator dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  ball_tensor_vote_accumulator_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("[ball_tensor_vote_accumulator] ERROR");
    $finish;
  end

  // Receiver: stall in random bursts while idling is on.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, logic last);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{point_x: x, point_y: y, point_z: z, last_point: last};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid, then wait for every tensor and for the engine to go quiet.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_t c);
    logic [CFG_IDX_W-1:0] idx [6];
    logic [31:0]          val [6];
    idx = '{CFG_SOURCE_X, CFG_SOURCE_Y, CFG_SOURCE_Z, CFG_INV_SIGMA_SQ,
            CFG_LAMBDA_SCALE, CFG_UNUSED_IDX};
    val = '{c.source_x, c.source_y, c.source_z, c.inv_sigma_sq, c.lambda_scale, $urandom};
    for (int i = 0; i < 6; i++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic logic signed [31:0] near_axis(logic signed [31:0] s);
    logic [31:0] off;
    case ($urandom_range(0, 5))
      0: return s;
      1: return $urandom;
      default: begin
        off = $urandom & ((32'd1 << $urandom_range(0, 20)) - 1);
        return $urandom_range(0, 1) ? s - off : s + off;
      end
    endcase
  endfunction

  task automatic random_phase(int count);
    logic last;
    for (int i = 0; i < count; i++) begin
      last = ($urandom_range(0, 7) == 0) || (i == count - 1);
      if ($urandom_range(0, 15) == 0) begin
        send_point(cur_cfg.source_x, cur_cfg.source_y, cur_cfg.source_z, last);
      end else begin
        send_point(near_axis(cur_cfg.source_x), near_axis(cur_cfg.source_y),
                   near_axis(cur_cfg.source_z), last);
      end
    end
  endtask

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 32'd1 << $urandom_range(8, 20);
      2:       return $urandom_range(0, 1 << 18);
      default: return 32'd65536;
    endcase
  endfunction

  initial begin
    cfg_t c;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    idle_on    = 1'b1;
    cur_cfg    = '{source_x: '0, source_y: '0, source_z: '0,
                   inv_sigma_sq: 32'd65536, lambda_scale: 32'd65536};
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: zero offset, tiny offset, unit axes, decay cutoff, extremes.
    send_point(0, 0, 0, 1'b1);
    send_point(1, 0, 0, 1'b1);
    send_point(1, -1, 1, 1'b0);
    send_point(0, 0, 0, 1'b1);
    send_point(32'sd65536, 0, 0, 1'b0);
    send_point(-32'sd65536, 32'sd65536, 0, 1'b1);
    send_point(32'sd131072, 32'sd131072, 32'sd131072, 1'b1);
    send_point(32'sh7fffffff, 0, 0, 1'b1);
    send_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0);
    send_point(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1);
    drain();

    write_cfg('{source_x: 32'sh80000000, source_y: 32'sh7fffffff, source_z: '0,
                inv_sigma_sq: 32'hffffffff, lambda_scale: 32'hffffffff});
    send_point(32'sh7fffffff, 32'sh80000000, 0, 1'b1);
    send_point(32'sh80000000, 32'sh7fffffff, 0, 1'b1);
    send_point(32'sh80000001, 32'sh7ffffffe, 32'sd3, 1'b1);
    send_point(32'sh80000100, 32'sh7fffff00, -32'sd256, 1'b1);
    drain();

    write_cfg('{source_x: 32'sd65536, source_y: -32'sd65536, source_z: 32'sh7fffffff,
                inv_sigma_sq: '0, lambda_scale: '0});
    send_point(32'sh7fffffff, 32'sh80000000, 0, 1'b1);
    send_point(32'sd65536, -32'sd65536, 32'sh7fffffff, 1'b1);
    drain();

    write_cfg('{source_x: '0, source_y: '0, source_z: '0,
                inv_sigma_sq: '0, lambda_scale: 32'hffffffff});
    send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
    send_point(32'sh80000000, 32'sd1, -32'sd1, 1'b1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      c.source_x     = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 1 << 20);
      c.source_y     = $urandom;
      c.source_z     = ($urandom_range(0, 1)) ? $urandom : '0;
      c.inv_sigma_sq = pick_scale();
      c.lambda_scale = pick_scale();
      write_cfg(c);
      if (ph == 3) begin
        idle_on = 1'b0;
      end
      random_phase(400);
      drain();
    end

    if (fail_count == 0) begin
      $display("[ball_tensor_vote_accumulator] OK");
    end else begin
      $display("[ball_tensor_vote_accumulator] ERROR");
    end
    $finish;
  end

endmodule
